@@ rtl/lwis_pkg.sv @@
`timescale 1ns / 1ps

package lwis_pkg;

   localparam int ID_W                = 32;
   localparam int WEIGHT_W            = 32;
   localparam int DEFAULT_MAX_ENTRIES = 16;

   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

   // one table row as held in the entry memory
   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [WEIGHT_W-1:0] weight;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

@@ rtl/lwis_ram.sv @@
`timescale 1ns / 1ps

module lwis_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/least_weight_id_selector_top.sv @@
`timescale 1ns / 1ps
// one transaction at a time: a request is taken only in the idle state, after the previous response
// has been loaded into the output register; the scan walks the stored entries in order through the
// single read port of the entry memory, one entry walked per cycle
// reset: synchronous, active high; clears the entry count and all handshake state,
// the entry memory itself is not cleared, entries at or above the count are never read

module least_weight_id_selector_top #(
   parameter int MAX_ENTRIES = lwis_pkg::DEFAULT_MAX_ENTRIES
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [lwis_pkg::ID_W-1:0]     req_server_id,
   input  logic [lwis_pkg::WEIGHT_W-1:0] req_load_add,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lwis_pkg::ID_W-1:0]     rsp_least_id,
   output logic                         rsp_table_full,
   output logic                         rsp_new_entry
);

   import lwis_pkg::*;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPEND,
      ST_DELIVER
   } state_type;

   // control state
   state_type          state_ff,       state_in;
   logic [CNT_W-1:0]   count_ff,       count_in;
   logic [IDX_W-1:0]   scan_idx_ff,    scan_idx_in;
   logic               found_ff,       found_in;
   logic               rsp_valid_ff,   rsp_valid_in;

   // working payload of the transaction in flight
   logic [ID_W-1:0]     id_ff,         id_in;
   logic [WEIGHT_W-1:0] add_ff,        add_in;
   logic [WEIGHT_W-1:0] best_w_ff,     best_w_in;
   logic [ID_W-1:0]     best_id_ff,    best_id_in;
   logic                full_ff,       full_in;
   logic                fresh_ff,      fresh_in;

   // response registers
   logic [ID_W-1:0]     rsp_least_id_ff,   rsp_least_id_in;
   logic                rsp_table_full_ff, rsp_table_full_in;
   logic                rsp_new_entry_ff,  rsp_new_entry_in;

   // memory port signals
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   entry_type          ram_wr_entry;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   entry_type          ram_rd_entry;
   logic [ENTRY_W-1:0] ram_rd_data;

   // entry datapath
   logic                hit;
   logic [WEIGHT_W:0]   sum;
   logic [WEIGHT_W-1:0] sat_w;
   logic [WEIGHT_W-1:0] cur_w;
   logic                last_entry;
   logic                table_is_full;
   logic                req_fire;

   lwis_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES),
      .ADDR_W(IDX_W)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_entry),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign ram_rd_entry = entry_type'(ram_rd_data);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // match, saturating accumulate and the weight that takes part in the minimum
   assign hit        = (ram_rd_entry.id == id_ff);
   assign sum        = {1'b0, ram_rd_entry.weight} + {1'b0, add_ff};
   assign sat_w      = sum[WEIGHT_W] ? WEIGHT_MAX : sum[WEIGHT_W-1:0];
   assign cur_w      = hit ? sat_w : ram_rd_entry.weight;
   assign last_entry = ((CNT_W'(scan_idx_ff) + CNT_W'(1)) == count_ff);
   assign table_is_full = (count_ff == CNT_W'(MAX_ENTRIES));

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      scan_idx_in       = scan_idx_ff;
      found_in          = found_ff;
      rsp_valid_in      = rsp_valid_ff;
      id_in             = id_ff;
      add_in            = add_ff;
      best_w_in         = best_w_ff;
      best_id_in        = best_id_ff;
      full_in           = full_ff;
      fresh_in          = fresh_ff;
      rsp_least_id_in   = rsp_least_id_ff;
      rsp_table_full_in = rsp_table_full_ff;
      rsp_new_entry_in  = rsp_new_entry_ff;

      ram_wr_en    = 1'b0;
      ram_wr_addr  = scan_idx_ff;
      ram_wr_entry = ram_rd_entry;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      // response leaves the output register
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               id_in       = req_server_id;
               add_in      = req_load_add;
               best_w_in   = WEIGHT_MAX;
               best_id_in  = '0;
               found_in    = 1'b0;
               full_in     = 1'b0;
               fresh_in    = 1'b0;
               scan_idx_in = '0;
               if (count_ff == '0) begin
                  state_in = ST_APPEND;
               end else begin
                  // first entry comes back next cycle
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = '0;
                  state_in    = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // ids are unique, so at most one entry hits
            if (hit) begin
               found_in            = 1'b1;
               ram_wr_en           = 1'b1;
               ram_wr_addr         = scan_idx_ff;
               ram_wr_entry.id     = ram_rd_entry.id;
               ram_wr_entry.weight = sat_w;
            end
            // strict compare keeps the earliest entry on ties
            if (cur_w < best_w_ff) begin
               best_w_in  = cur_w;
               best_id_in = ram_rd_entry.id;
            end
            if (last_entry) begin
               state_in = ST_APPEND;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = scan_idx_ff + IDX_W'(1);
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end

         ST_APPEND: begin
            if (!found_ff) begin
               if (table_is_full) begin
                  full_in = 1'b1;
               end else begin
                  ram_wr_en           = 1'b1;
                  ram_wr_addr         = count_ff[IDX_W-1:0];
                  ram_wr_entry.id     = id_ff;
                  ram_wr_entry.weight = add_ff;
                  count_in            = count_ff + CNT_W'(1);
                  fresh_in            = 1'b1;
                  // new entry is last in insertion order
                  if (add_ff < best_w_ff) begin
                     best_w_in  = add_ff;
                     best_id_in = id_ff;
                  end
               end
            end
            state_in = ST_DELIVER;
         end

         ST_DELIVER: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_least_id_in   = best_id_ff;
               rsp_table_full_in = full_ff;
               rsp_new_entry_in  = fresh_ff;
               state_in          = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_idx_ff  <= scan_idx_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      id_ff             <= id_in;
      add_ff            <= add_in;
      best_w_ff         <= best_w_in;
      best_id_ff        <= best_id_in;
      full_ff           <= full_in;
      fresh_ff          <= fresh_in;
      rsp_least_id_ff   <= rsp_least_id_in;
      rsp_table_full_ff <= rsp_table_full_in;
      rsp_new_entry_ff  <= rsp_new_entry_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_least_id   = rsp_least_id_ff;
   assign rsp_table_full = rsp_table_full_ff;
   assign rsp_new_entry  = rsp_new_entry_ff;

   // entry count never runs past the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count beyond table size");

   // the count only moves by one, and only while appending
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ($past(state_ff) == ST_APPEND) && (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("entry count changed outside an append");

   // a dropped transaction is reported only with a full table
   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_table_full_ff) |-> (table_is_full && !rsp_new_entry_ff))
      else $error("table full reported while entries remain");

endmodule
